### sv/tbt_pkg.sv
// Tombstone table package: table sizing, codes, controller states and store structs.
// No dependencies; compile first.
package tbt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int LIVE_W        = $clog2(TABLE_ENTRIES + 1);
   localparam int KEY_W         = 32;
   localparam int FRAME_W       = 32;
   localparam int CAP_W         = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [1:0] ACT_RECORD = 2'd0;
   localparam logic [1:0] ACT_QUERY  = 2'd1;
   localparam logic [1:0] ACT_ERASE  = 2'd2;

   localparam logic [1:0] OUT_IGNORED  = 2'd0;
   localparam logic [1:0] OUT_INSERTED = 2'd1;
   localparam logic [1:0] OUT_UPDATED  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS,
      ST_DECIDE,
      ST_FRAME_WR,
      ST_INSERT,
      ST_CHECK,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      PASS_SCAN,
      PASS_UPDATE,
      PASS_REMOVE,
      PASS_TRIM
   } pass_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [FRAME_W-1:0] frame;
      logic [IDX_W-1:0]   rank;
   } slot_type;

   typedef struct packed {
      logic [IDX_W-1:0]   addr;
      logic               key_en;
      logic               frame_en;
      logic               rank_en;
      logic               valid_set;
      logic               valid_clr;
      logic [KEY_W-1:0]   key;
      logic [FRAME_W-1:0] frame;
      logic [IDX_W-1:0]   rank;
   } store_wr_type;

endpackage

### sv/tbt_if.sv
// Request and response channel interfaces of the tombstone table.
// Depends on tbt_pkg for field widths.
interface tbt_req_if import tbt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [KEY_W-1:0]   item_key;
   logic [FRAME_W-1:0] frame_number;

   modport source (output valid, action, item_key, frame_number, input ready);
   modport sink   (input valid, action, item_key, frame_number, output ready);
endinterface

interface tbt_rsp_if import tbt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       record_outcome;
   logic             is_blocked;
   logic             did_evict;
   logic [KEY_W-1:0] evicted_key;

   modport source (output valid, record_outcome, is_blocked, did_evict, evicted_key,
                   input ready);
   modport sink   (input valid, record_outcome, is_blocked, did_evict, evicted_key,
                   output ready);
endinterface

### sv/bounded_tombstone_table.sv
// Bounded tombstone table, top level: sequencer over the slot store.
// Sequence: a full scan pass over every slot, decide, then respond; an insert or update adds up to
// two more passes and the frame-write or insert and check states, an erase that hits one remove pass.
// Flow: one word at a time; ready returns as the response word is loaded into the output register.
// Reset: synchronous, active high; clears valid flops, live count, limit to 64.
// Depends on tbt_pkg, tbt_if, tbt_store.
module bounded_tombstone_table import tbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   tbt_req_if.sink          req_ch,
   tbt_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   state_type state_ff, state_in, after_ff, after_in;
   pass_type  kind_ff, kind_in;

   logic [LIVE_W-1:0]  idx_ff, idx_in;
   logic               pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]   pipe_addr_ff, pipe_addr_in;
   logic [LIVE_W-1:0]  live_ff, live_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [LIVE_W-1:0]  lim;
   logic [LIVE_W-1:0]  e_ff, e_in;

   // held item
   logic [1:0]         act_ff, act_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [FRAME_W-1:0] frm_ff, frm_in;

   // scan results
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   s_ff, s_in;
   logic [FRAME_W-1:0] sframe_ff, sframe_in;
   logic [IDX_W-1:0]   srank_ff, srank_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   f_ff, f_in;
   logic [KEY_W-1:0]   oldkey_ff, oldkey_in;
   logic [IDX_W-1:0]   oldslot_ff, oldslot_in;

   // result under construction
   logic [1:0]         outc_ff, outc_in;
   logic               blk_ff, blk_in;
   logic               ev_ff, ev_in;
   logic [KEY_W-1:0]   evkey_ff, evkey_in;

   // output register
   logic               rspv_ff, rspv_in;
   logic [1:0]         r_outc_ff, r_outc_in;
   logic               r_blk_ff, r_blk_in;
   logic               r_ev_ff, r_ev_in;
   logic [KEY_W-1:0]   r_evkey_ff, r_evkey_in;

   logic [IDX_W-1:0]   rd_addr;
   store_wr_type       wr;
   slot_type           rd;

   tbt_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_addr(rd_addr),
      .wr     (wr),
      .rd     (rd)
   );

   // Effective limit: zero acts as one, anything above the table size as the size.
   always_comb begin
      if (cap_ff == '0) begin
         lim = LIVE_W'(1);
      end else if (32'(cap_ff) > 32'(TABLE_ENTRIES)) begin
         lim = LIVE_W'(TABLE_ENTRIES);
      end else begin
         lim = LIVE_W'(cap_ff);
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rspv_ff;
   assign rsp_ch.record_outcome = r_outc_ff;
   assign rsp_ch.is_blocked     = r_blk_ff;
   assign rsp_ch.did_evict      = r_ev_ff;
   assign rsp_ch.evicted_key    = r_evkey_ff;
   assign rd_addr               = idx_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      pipe_vld_in  = 1'b0;
      pipe_addr_in = pipe_addr_ff;
      live_in      = live_ff;
      e_in         = e_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      frm_in       = frm_ff;
      hit_in       = hit_ff;
      s_in         = s_ff;
      sframe_in    = sframe_ff;
      srank_in     = srank_ff;
      free_in      = free_ff;
      f_in         = f_ff;
      oldkey_in    = oldkey_ff;
      oldslot_in   = oldslot_ff;
      outc_in      = outc_ff;
      blk_in       = blk_ff;
      ev_in        = ev_ff;
      evkey_in     = evkey_ff;
      rspv_in      = rspv_ff;
      r_outc_in    = r_outc_ff;
      r_blk_in     = r_blk_ff;
      r_ev_in      = r_ev_ff;
      r_evkey_in   = r_evkey_ff;
      wr           = '0;

      // drop the response word once taken
      if (rspv_ff && rsp_ch.ready) begin
         rspv_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               act_in   = req_ch.action;
               key_in   = req_ch.item_key;
               frm_in   = req_ch.frame_number;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               outc_in  = OUT_IGNORED;
               blk_in   = 1'b0;
               ev_in    = 1'b0;
               evkey_in = '0;
               kind_in  = PASS_SCAN;
               after_in = ST_DECIDE;
               idx_in   = '0;
               state_in = ST_PASS;
            end
         end

         ST_PASS: begin
            // issue a read a cycle; the slot arrives in the cycle after
            if (idx_ff < LIVE_W'(TABLE_ENTRIES)) begin
               pipe_vld_in  = 1'b1;
               pipe_addr_in = idx_ff[IDX_W-1:0];
               idx_in       = idx_ff + LIVE_W'(1);
            end
            if (pipe_vld_ff) begin
               wr.addr = pipe_addr_ff;
               unique case (kind_ff)
                  PASS_SCAN: begin
                     if (rd.valid && rd.key == key_ff) begin
                        hit_in    = 1'b1;
                        s_in      = pipe_addr_ff;
                        sframe_in = rd.frame;
                        srank_in  = rd.rank;
                     end
                     if (!rd.valid && !free_ff) begin
                        free_in = 1'b1;
                        f_in    = pipe_addr_ff;
                     end
                     if (rd.valid && rd.rank == '0) begin
                        oldkey_in  = rd.key;
                        oldslot_in = pipe_addr_ff;
                     end
                  end
                  PASS_UPDATE: begin
                     // make the hit slot newest, close the gap it leaves
                     if (rd.valid) begin
                        if (pipe_addr_ff == s_ff) begin
                           wr.rank_en = 1'b1;
                           wr.rank    = IDX_W'(live_ff - LIVE_W'(1));
                        end else if (rd.rank > srank_ff) begin
                           wr.rank_en = 1'b1;
                           wr.rank    = rd.rank - IDX_W'(1);
                        end
                     end
                  end
                  PASS_REMOVE: begin
                     if (pipe_addr_ff == s_ff) begin
                        wr.valid_clr = 1'b1;
                     end else if (rd.valid && rd.rank > srank_ff) begin
                        wr.rank_en = 1'b1;
                        wr.rank    = rd.rank - IDX_W'(1);
                     end
                  end
                  PASS_TRIM: begin
                     // evict the e oldest at once, shift the rest down by e
                     if (rd.valid) begin
                        if (LIVE_W'(rd.rank) < e_ff) begin
                           wr.valid_clr = 1'b1;
                           if (rd.rank == '0 && !ev_ff) begin
                              ev_in    = 1'b1;
                              evkey_in = rd.key;
                           end
                        end else begin
                           wr.rank_en = 1'b1;
                           wr.rank    = IDX_W'(LIVE_W'(rd.rank) - e_ff);
                        end
                     end
                  end
                  default: ;
               endcase
               if (pipe_addr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  state_in = after_ff;
                  if (kind_ff == PASS_REMOVE) begin
                     live_in = live_ff - LIVE_W'(1);
                  end else if (kind_ff == PASS_TRIM) begin
                     live_in = live_ff - e_ff;
                  end
               end
            end
         end

         ST_DECIDE: begin
            idx_in   = '0;
            state_in = ST_RESP;
            priority if (act_ff == ACT_RECORD && key_ff != '0) begin
               if (hit_ff) begin
                  if (frm_ff > sframe_ff) begin
                     outc_in  = OUT_UPDATED;
                     state_in = ST_FRAME_WR;
                  end
               end else if (live_ff >= LIVE_W'(TABLE_ENTRIES)) begin
                  // full: evict the oldest and reuse its slot
                  ev_in    = 1'b1;
                  evkey_in = oldkey_ff;
                  f_in     = oldslot_ff;
                  e_in     = LIVE_W'(1);
                  kind_in  = PASS_TRIM;
                  after_in = ST_INSERT;
                  state_in = ST_PASS;
               end else begin
                  state_in = ST_INSERT;
               end
            end else if (act_ff == ACT_QUERY) begin
               blk_in = hit_ff && (frm_ff <= sframe_ff);
            end else if (act_ff == ACT_ERASE) begin
               if (hit_ff) begin
                  kind_in  = PASS_REMOVE;
                  after_in = ST_RESP;
                  state_in = ST_PASS;
               end
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_FRAME_WR: begin
            wr.addr     = s_ff;
            wr.frame_en = 1'b1;
            wr.frame    = frm_ff;
            idx_in      = '0;
            kind_in     = PASS_UPDATE;
            after_in    = ST_CHECK;
            state_in    = ST_PASS;
         end

         ST_INSERT: begin
            wr.addr      = f_ff;
            wr.key_en    = 1'b1;
            wr.frame_en  = 1'b1;
            wr.rank_en   = 1'b1;
            wr.valid_set = 1'b1;
            wr.key       = key_ff;
            wr.frame     = frm_ff;
            wr.rank      = IDX_W'(live_ff);
            live_in      = live_ff + LIVE_W'(1);
            outc_in      = OUT_INSERTED;
            state_in     = ST_CHECK;
         end

         ST_CHECK: begin
            idx_in = '0;
            if (live_ff > lim) begin
               e_in     = live_ff - lim;
               kind_in  = PASS_TRIM;
               after_in = ST_RESP;
               state_in = ST_PASS;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            // hold until the output register is free
            if (!rspv_ff || rsp_ch.ready) begin
               rspv_in    = 1'b1;
               r_outc_in  = outc_ff;
               r_blk_in   = blk_ff;
               r_ev_in    = ev_ff;
               r_evkey_in = evkey_ff;
               state_in   = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pipe_vld_ff <= 1'b0;
         live_ff     <= '0;
         cap_ff      <= CAP_RESET;
         rspv_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= pipe_vld_in;
         live_ff     <= live_in;
         rspv_ff     <= rspv_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      after_ff     <= after_in;
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      pipe_addr_ff <= pipe_addr_in;
      e_ff         <= e_in;
      act_ff       <= act_in;
      key_ff       <= key_in;
      frm_ff       <= frm_in;
      hit_ff       <= hit_in;
      s_ff         <= s_in;
      sframe_ff    <= sframe_in;
      srank_ff     <= srank_in;
      free_ff      <= free_in;
      f_ff         <= f_in;
      oldkey_ff    <= oldkey_in;
      oldslot_ff   <= oldslot_in;
      outc_ff      <= outc_in;
      blk_ff       <= blk_in;
      ev_ff        <= ev_in;
      evkey_ff     <= evkey_in;
      r_outc_ff    <= r_outc_in;
      r_blk_ff     <= r_blk_in;
      r_ev_ff      <= r_ev_in;
      r_evkey_ff   <= r_evkey_in;
   end

   // live count never passes the table size
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LIVE_W'(TABLE_ENTRIES))
      else $error("live count above table size");

   // an eviction only ever comes from a record that took effect
   a_evict_outcome: assert property (@(posedge clock) disable iff (reset)
      rspv_ff && r_ev_ff |-> r_outc_ff != OUT_IGNORED)
      else $error("eviction without insert or update");

   // no evicted key reported without an eviction
   a_evict_key: assert property (@(posedge clock) disable iff (reset)
      rspv_ff && !r_ev_ff |-> r_evkey_ff == '0)
      else $error("evicted key without eviction");

endmodule

### sv/tbt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/tbt_store.sv
// Slot store: key, frame and age-rank memories plus per-slot valid flops.
// Depends on tbt_pkg and tbt_ram.
module tbt_store import tbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   input  store_wr_type     wr,
   output slot_type         rd
);
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic                     rd_valid_ff;

   tbt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key (
      .clock(clock), .wr_en(wr.key_en), .wr_addr(wr.addr), .wr_data(wr.key),
      .rd_addr(rd_addr), .rd_data(rd.key));

   tbt_ram #(.WIDTH(FRAME_W), .DEPTH(TABLE_ENTRIES)) u_frame (
      .clock(clock), .wr_en(wr.frame_en), .wr_addr(wr.addr), .wr_data(wr.frame),
      .rd_addr(rd_addr), .rd_data(rd.frame));

   tbt_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_rank (
      .clock(clock), .wr_en(wr.rank_en), .wr_addr(wr.addr), .wr_data(wr.rank),
      .rd_addr(rd_addr), .rd_data(rd.rank));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.valid_set) begin
            valid_ff[wr.addr] <= 1'b1;
         end else if (wr.valid_clr) begin
            valid_ff[wr.addr] <= 1'b0;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd.valid = rd_valid_ff;
endmodule

### tb/tbt_score.sv
// Scoreboard for the tombstone table testbench: predicts each response word.
// Depends on tbt_pkg; compile after the RTL interfaces.
`timescale 1ns / 1ps
package tbt_score_pkg;
   import tbt_pkg::*;

   typedef struct packed {
      logic [1:0]       outcome;
      logic             blocked;
      logic             evicted;
      logic [KEY_W-1:0] ev_key;
   } verdict_type;

   class tombstone_score;
      bit               live [TABLE_ENTRIES];
      bit [KEY_W-1:0]   keys [TABLE_ENTRIES];
      bit [FRAME_W-1:0] frames [TABLE_ENTRIES];
      int               ranks [TABLE_ENTRIES];
      int               count;
      int               limit;
      int               errors;
      verdict_type      pending [$];

      function new();
         count  = 0;
         limit  = CAP_RESET;
         errors = 0;
         foreach (live[i]) live[i] = 0;
      endfunction

      function void set_limit(bit [CAP_W-1:0] v);
         limit = v;
      endfunction

      function int lookup(bit [KEY_W-1:0] k);
         foreach (live[i]) if (live[i] && keys[i] == k) return i;
         return -1;
      endfunction

      function void drop_slot(int s);
         live[s] = 0;
         foreach (live[i]) if (live[i] && ranks[i] > ranks[s]) ranks[i]--;
         if (count > 0) count--;
      endfunction

      function bit [KEY_W-1:0] drop_oldest();
         foreach (live[i]) if (live[i] && ranks[i] == 0) begin
            drop_slot(i);
            return keys[i];
         end
         return 0;
      endfunction

      // note an accepted request word and queue its expected response
      function void note_request(logic [1:0] act, bit [KEY_W-1:0] k, bit [FRAME_W-1:0] f);
         verdict_type v;
         int s, lim, fr;
         v = '0;
         s = lookup(k);
         if (act == ACT_RECORD && k != 0) begin
            if (s >= 0) begin
               if (f > frames[s]) begin
                  foreach (live[i]) if (live[i] && ranks[i] > ranks[s]) ranks[i]--;
                  frames[s] = f;
                  ranks[s]  = count - 1;
                  v.outcome = OUT_UPDATED;
               end
            end else begin
               if (count >= TABLE_ENTRIES) begin
                  v.evicted = 1;
                  v.ev_key  = drop_oldest();
               end
               fr = -1;
               foreach (live[i]) if (!live[i] && fr < 0) fr = i;
               live[fr] = 1; keys[fr] = k; frames[fr] = f; ranks[fr] = count;
               count++;
               v.outcome = OUT_INSERTED;
            end
            if (v.outcome != OUT_IGNORED) begin
               lim = (limit == 0) ? 1 : (limit > TABLE_ENTRIES ? TABLE_ENTRIES : limit);
               while (count > lim) begin
                  if (!v.evicted) begin
                     v.evicted = 1;
                     v.ev_key  = drop_oldest();
                  end else void'(drop_oldest());
               end
            end
         end else if (act == ACT_QUERY) begin
            v.blocked = (s >= 0) && (f <= frames[s]);
         end else if (act == ACT_ERASE) begin
            if (s >= 0) drop_slot(s);
         end
         pending.insert(pending.size(), v);
      endfunction

      function void check_response(verdict_type got);
         verdict_type e;
         if (pending.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.outcome !== e.outcome) begin
            $error("record_outcome exp %0d got %0d", e.outcome, got.outcome); errors++;
         end
         if (got.blocked !== e.blocked) begin
            $error("is_blocked exp %0d got %0d", e.blocked, got.blocked); errors++;
         end
         if (got.evicted !== e.evicted) begin
            $error("did_evict exp %0d got %0d", e.evicted, got.evicted); errors++;
         end
         if (got.ev_key !== e.ev_key) begin
            $error("evicted_key exp %h got %h", e.ev_key, got.ev_key); errors++;
         end
      endfunction
   endclass
endpackage

### tb/testbench.sv
// Top-level testbench for bounded_tombstone_table: drives request words,
// checks response words against the scoreboard. Depends on tbt_pkg, tbt_if, tbt_score_pkg.
`timescale 1ns / 1ps
module testbench;
   import tbt_pkg::*;
   import tbt_score_pkg::*;

   // action code outside the defined set
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic             clock = 0;
   logic             reset = 1;
   logic             csr_wr_en = 0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   tbt_req_if req_ch ();
   tbt_rsp_if rsp_ch ();

   tombstone_score score = new();

   int  send_idle_pct = 0;   // chance, in percent, that the sender skips a cycle
   int  stall_pct     = 0;   // chance that the receiver stalls a cycle
   bit  hold_off      = 0;   // long receiver hold-off for back-pressure
   int  accepted_rsp  = 0;

   // pool of keys reused so records hit, update and evict each other
   logic [KEY_W-1:0] key_pool [32];

   bounded_tombstone_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // receiver: random stalls, or a long hold-off while pressure is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
      end
   end

   // check each accepted response word
   always @(posedge clock) begin
      verdict_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.outcome = rsp_ch.record_outcome;
         got.blocked = rsp_ch.is_blocked;
         got.evicted = rsp_ch.did_evict;
         got.ev_key  = rsp_ch.evicted_key;
         score.check_response(got);
         accepted_rsp++;
      end
   end

   // offer one request word, hold it until accepted, then note it
   task automatic send_word(logic [1:0] act, logic [KEY_W-1:0] k, logic [FRAME_W-1:0] f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid        <= 1;
      req_ch.action       <= act;
      req_ch.item_key     <= k;
      req_ch.frame_number <= f;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      score.note_request(act, k, f);
   endtask

   task automatic drain();
      @(posedge clock);
      req_ch.valid <= 0;
      while (score.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // write the limit only when idle
   task automatic write_limit(logic [CAP_W-1:0] v);
      csr_wr_en   <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 0;
      score.set_limit(v);
      @(posedge clock);
   endtask

   task automatic random_word();
      logic [1:0]       act;
      logic [KEY_W-1:0] k;
      logic [FRAME_W-1:0] f;
      int r;
      r = $urandom_range(99);
      act = (r < 55) ? ACT_RECORD : (r < 80) ? ACT_QUERY : (r < 97) ? ACT_ERASE : ACT_UNUSED;
      k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(31)];
      if ($urandom_range(30) == 0) k = 0;
      f = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(200);
      send_word(act, k, f);
   endtask

   task automatic run_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (n) random_word();
      drain();
   endtask

   initial begin
      req_ch.valid        = 0;
      req_ch.action       = ACT_RECORD;
      req_ch.item_key     = '0;
      req_ch.frame_number = '0;
      foreach (key_pool[i]) key_pool[i] = $urandom() | 1;
      key_pool[0] = 32'hFFFF_FFFF;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every action, zero key, not newer, absent keys
      send_word(ACT_RECORD, 32'h0, 32'h5);
      send_word(ACT_RECORD, 32'hFFFF_FFFF, 32'h0);
      send_word(ACT_RECORD, 32'hFFFF_FFFF, 32'h0);
      send_word(ACT_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(ACT_RECORD, 32'h1, 32'h10);
      send_word(ACT_RECORD, 32'h1, 32'h8);
      send_word(ACT_QUERY, 32'h1, 32'h10);
      send_word(ACT_QUERY, 32'h1, 32'h11);
      send_word(ACT_QUERY, 32'h1234, 32'h0);
      send_word(ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(ACT_ERASE, 32'h1234, 32'h0);
      send_word(ACT_ERASE, 32'h1, 32'h0);
      send_word(ACT_QUERY, 32'h1, 32'h0);
      send_word(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // fill past the table size so a full insert evicts
      for (int i = 0; i < 66; i++) send_word(ACT_RECORD, 32'h100 + i, i);
      drain();

      // lowered limit trims several entries at once
      write_limit(7'd3);
      send_word(ACT_RECORD, 32'h100 + 65, 32'h1000);
      drain();
      write_limit(7'd0);
      send_word(ACT_RECORD, 32'hAAAA_5555, 32'h7);
      send_word(ACT_RECORD, 32'h5555_AAAA, 32'h7);
      drain();
      write_limit(7'd127);
      run_phase(150, 0, 0);

      // pressure: hold off the receiver while the sender keeps offering
      hold_off = 1;
      fork
         repeat (5) random_word();
         begin repeat (2000) @(posedge clock); hold_off = 0; end
      join
      drain();

      write_limit(7'd64);
      run_phase(400, 0, 0);
      write_limit(7'd20);
      run_phase(350, 82, 0);
      write_limit(7'd1);
      run_phase(200, 0, 82);
      write_limit(7'd8);
      run_phase(350, 31, 31);
      write_limit(7'd65);
      run_phase(300, 0, 0);

      if (score.errors == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

   initial begin
      #400ms;
      $display("testbench: errors");
      $finish;
   end
endmodule

### bounded_tombstone_table.f
sv/tbt_pkg.sv
sv/tbt_if.sv
sv/tbt_ram.sv
sv/tbt_store.sv
sv/bounded_tombstone_table.sv
tb/tbt_score.sv
tb/testbench.sv
